FILE: design/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    // Store geometry
    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 3;

    // Word kinds on the input channel
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SRCH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sort_init;
        logic sort_first;
        logic sort_cmp;
        logic sort_tail;
        logic srch_init;
        logic srch_issue;
        logic srch_cmp;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sort_short;
        logic cmp_more;
        logic tail_stop;
        logic srch_empty;
        logic srch_hit;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/sort_then_binary_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Fields
// s_        in   s_valid / s_ready  s_kind, s_value, s_last
// m_        out  m_valid / m_ready  m_found, m_position, m_overflow
//
// A load word is handled as it is accepted. A closing load then runs a setup state, then
// passes of load, compare and tail states through the single read port; passes stop early when nothing moved.
// A search: its accept, an issue and a compare state per halving step (registered store read), at most
// log2(DEPTH)+1 steps, one more issue state when the range runs empty, and an output state to load the word.
// Synchronous active-low reset empties the set and drops any pending output word.
// A pending result word does not block loads; a search waits only to hand over its word.
module sort_then_binary_search (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_kind,
    input  wire logic signed [stbs_pkg::DATA_W-1:0]  s_value,
    input  wire logic                                s_last,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_found,
    output logic [stbs_pkg::POS_W-1:0]               m_position,
    output logic                                     m_overflow
);

    stbs_pkg::cmd_t cmd;
    stbs_pkg::sts_t sts;

    stbs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind (s_kind),
        .s_last (s_last),
        .sts    (sts),
        .cmd    (cmd)
    );

    stbs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_value   (s_value),
        .s_last    (s_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_found   (m_found),
        .m_position(m_position),
        .m_overflow(m_overflow)
    );

    // A load word never produces a result word
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == stbs_pkg::KIND_LOAD) |=> !$rose(m_valid))
        else $error("result word raised after a load word");

    // A search holds off the next word while it runs
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == stbs_pkg::KIND_SRCH) |=> !s_ready)
        else $error("input accepted during a search");

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

endmodule

`default_nettype wire

FILE: design/stbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                          aclk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: design/stbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: element store, set bookkeeping, sort and search registers, output word
module stbs_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire stbs_pkg::cmd_t                       cmd,
    output stbs_pkg::sts_t                            sts,
    input  wire logic signed [stbs_pkg::DATA_W-1:0]   s_value,
    input  wire logic                                 s_last,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_found,
    output logic [stbs_pkg::POS_W-1:0]                m_position,
    output logic                                      m_overflow
);

    localparam int DW = stbs_pkg::DATA_W;
    localparam int IW = stbs_pkg::IDX_W;
    localparam int CW = stbs_pkg::CNT_W;
    localparam int PW = stbs_pkg::POS_W;

    // Set bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic          closed_reg, closed_next;
    logic          ovf_reg, ovf_next;

    // Sort state
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        limit_reg, limit_next;
    logic signed [DW-1:0] carry_reg, carry_next;
    logic                 moved_reg, moved_next;

    // Search state
    logic signed [DW-1:0] key_reg, key_next;
    logic [CW-1:0]        low_reg, low_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic                 found_reg, found_next;
    logic [PW-1:0]        pos_reg, pos_next;

    // Output word
    logic          m_valid_reg, m_valid_next;
    logic          m_found_reg, m_found_next;
    logic [PW-1:0] m_pos_reg, m_pos_next;
    logic          m_ovf_reg, m_ovf_next;

    // Store port signals
    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    logic [DW-1:0]        wdata;
    logic [DW-1:0]        rdata_raw;
    logic signed [DW-1:0] rdata;

    // Helpers
    logic [CW-1:0]    eff_count;
    logic             full;
    logic [CW:0]      mid_sum;
    logic [CW:0]      mid_full;
    logic [IW-1:0]    mid;
    logic [IW+PW-1:0] mid_ext;
    logic [CW-1:0]    j_plus1, j_plus2;
    logic             swap;

    stbs_ram #(
        .WIDTH(DW),
        .DEPTH(stbs_pkg::DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata_raw)
    );

    assign rdata = rdata_raw;

    // Index arithmetic
    assign eff_count = closed_reg ? '0 : count_reg;
    assign full      = (eff_count >= CW'(stbs_pkg::DEPTH));
    assign mid_sum   = {1'b0, low_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid_full  = mid_sum >> 1;
    assign mid       = mid_full[IW-1:0];
    assign mid_ext   = {{PW{1'b0}}, mid};
    assign j_plus1   = j_reg + CW'(1);
    assign j_plus2   = j_reg + CW'(2);
    assign swap      = (carry_reg > rdata);

    // Status toward the controller
    always_comb begin
        sts.sort_short = (count_reg < CW'(2));
        sts.cmp_more   = (j_plus1 < limit_reg);
        sts.tail_stop  = !moved_reg || (limit_reg == CW'(1));
        sts.srch_empty = !(low_reg < hi_reg);
        sts.srch_hit   = (rdata == key_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Store port steering
    always_comb begin
        we    = 1'b0;
        waddr = eff_count[IW-1:0];
        wdata = s_value;
        raddr = '0;
        if (cmd.load) begin
            we = !full;
        end
        if (cmd.sort_first) begin
            raddr = IW'(1);
        end
        if (cmd.sort_cmp) begin
            we    = 1'b1;
            waddr = j_reg[IW-1:0];
            wdata = swap ? rdata : carry_reg;
            raddr = j_plus2[IW-1:0];
        end
        if (cmd.sort_tail) begin
            we    = 1'b1;
            waddr = limit_reg[IW-1:0];
            wdata = carry_reg;
        end
        if (cmd.srch_issue) begin
            raddr = mid;
        end
    end

    // Next-state logic
    always_comb begin
        count_next   = count_reg;
        closed_next  = closed_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        limit_next   = limit_reg;
        carry_next   = carry_reg;
        moved_next   = moved_reg;
        key_next     = key_reg;
        low_next     = low_reg;
        hi_next      = hi_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        m_ovf_next   = m_ovf_reg;

        // load word: open a new set if needed, append or flag overflow
        if (cmd.load) begin
            count_next  = full ? eff_count : eff_count + CW'(1);
            ovf_next    = (closed_reg ? 1'b0 : ovf_reg) | full;
            closed_next = s_last;
        end

        // bubble pass: carry holds the running maximum
        if (cmd.sort_init) begin
            limit_next = count_reg - CW'(1);
        end
        if (cmd.sort_first) begin
            carry_next = rdata;
            moved_next = 1'b0;
            j_next     = '0;
        end
        if (cmd.sort_cmp) begin
            j_next = j_plus1;
            if (swap) begin
                moved_next = 1'b1;
            end else begin
                carry_next = rdata;
            end
        end
        if (cmd.sort_tail) begin
            limit_next = limit_reg - CW'(1);
        end

        // halving search over [low, hi)
        if (cmd.srch_init) begin
            key_next   = s_value;
            low_next   = '0;
            hi_next    = count_reg;
            found_next = 1'b0;
            pos_next   = '0;
        end
        if (cmd.srch_cmp) begin
            if (rdata == key_reg) begin
                found_next = 1'b1;
                pos_next   = mid_ext[PW-1:0];
            end else if (key_reg > rdata) begin
                low_next = {{(CW-IW){1'b0}}, mid} + CW'(1);
            end else begin
                hi_next = {{(CW-IW){1'b0}}, mid};
            end
        end

        // output word
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_found_next = found_reg;
            m_pos_next   = pos_reg;
            m_ovf_next   = ovf_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            closed_reg  <= 1'b1;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            closed_reg  <= closed_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        j_reg       <= j_next;
        limit_reg   <= limit_next;
        carry_reg   <= carry_next;
        moved_reg   <= moved_next;
        key_reg     <= key_next;
        low_reg     <= low_next;
        hi_reg      <= hi_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;
    assign m_overflow = m_ovf_reg;

endmodule

`default_nettype wire

FILE: design/stbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Controller: sequences loads, the sort passes and the search steps
module stbs_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_kind,
    input  wire logic           s_last,
    input  wire stbs_pkg::sts_t sts,
    output stbs_pkg::cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SORT_INIT = 8'b0000_0010,
        S_SORT_LOAD = 8'b0000_0100,
        S_SORT_CMP  = 8'b0000_1000,
        S_SORT_TAIL = 8'b0001_0000,
        S_SRCH_ISS  = 8'b0010_0000,
        S_SRCH_CMP  = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == stbs_pkg::KIND_LOAD) begin
                        cmd.load = 1'b1;
                        if (s_last) begin
                            state_next = S_SORT_INIT;
                        end
                    end else begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_SRCH_ISS;
                    end
                end
            end
            S_SORT_INIT: begin
                if (sts.sort_short) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.sort_init = 1'b1;
                    state_next    = S_SORT_LOAD;
                end
            end
            S_SORT_LOAD: begin
                cmd.sort_first = 1'b1;
                state_next     = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                cmd.sort_cmp = 1'b1;
                if (!sts.cmp_more) begin
                    state_next = S_SORT_TAIL;
                end
            end
            S_SORT_TAIL: begin
                cmd.sort_tail = 1'b1;
                // no swap in this pass, or nothing left to bubble: done
                state_next    = sts.tail_stop ? S_IDLE : S_SORT_LOAD;
            end
            S_SRCH_ISS: begin
                if (sts.srch_empty) begin
                    state_next = S_OUT;
                end else begin
                    cmd.srch_issue = 1'b1;
                    state_next     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = sts.srch_hit ? S_OUT : S_SRCH_ISS;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 64;
    localparam int WORD_TARGET    = 1150;

    typedef logic signed [stbs_pkg::DATA_W-1:0] elem_t;

    // One search answer as the result channel carries it
    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::POS_W-1:0] position;
        logic                       overflow;
    } answer_t;

    // Tracks the element set and queues the answer of every accepted search word
    class sorted_set_tracker;
        elem_t       elems[stbs_pkg::DEPTH];
        int unsigned n_elems;
        bit          set_done;
        bit          dropped;
        answer_t     answers[$];
        int          errors;

        function new();
            n_elems  = 0;
            set_done = 1'b1;
            dropped  = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function void take_word(logic kind, elem_t value, logic last);
            int      lo;
            int      hi;
            int      mid;
            bit      moved;
            elem_t   tmp;
            answer_t ans;
            if (kind == stbs_pkg::KIND_LOAD) begin
                // first load after a closed set opens a fresh one
                if (set_done) begin
                    n_elems  = 0;
                    dropped  = 1'b0;
                    set_done = 1'b0;
                end
                if (n_elems < stbs_pkg::DEPTH) begin
                    elems[n_elems] = value;
                    n_elems++;
                end else begin
                    dropped = 1'b1;
                end
                // closing load: bubble sort, stop after a pass without a swap
                if (last) begin
                    for (int p = 0; p + 1 < int'(n_elems); p++) begin
                        moved = 1'b0;
                        for (int j = 0; j + 1 < int'(n_elems) - p; j++) begin
                            if (elems[j] > elems[j+1]) begin
                                tmp        = elems[j];
                                elems[j]   = elems[j+1];
                                elems[j+1] = tmp;
                                moved      = 1'b1;
                            end
                        end
                        if (!moved) break;
                    end
                    set_done = 1'b1;
                end
            end else begin
                // halving search over the entries held right now
                ans = '0;
                lo  = 0;
                hi  = int'(n_elems) - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (elems[mid] == value) begin
                        ans.found    = 1'b1;
                        ans.position = mid[stbs_pkg::POS_W-1:0];
                        break;
                    end else if (value > elems[mid]) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                ans.overflow = dropped;
                answers.push_back(ans);
            end
        endfunction

        function void check_result(logic found, logic [stbs_pkg::POS_W-1:0] position,
                                   logic overflow);
            answer_t exp_ans;
            if (answers.size() == 0) begin
                $error("result word with no search pending: found %0b position %0d",
                       found, position);
                errors++;
                return;
            end
            exp_ans = answers.pop_front();
            if (found !== exp_ans.found) begin
                $error("found: expected %0b, got %0b", exp_ans.found, found);
                errors++;
            end
            if (position !== exp_ans.position) begin
                $error("position: expected %0d, got %0d", exp_ans.position, position);
                errors++;
            end
            if (overflow !== exp_ans.overflow) begin
                $error("overflow: expected %0b, got %0b", exp_ans.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk       = 1'b0;
    logic                       aresetn    = 1'b0;
    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic                       s_kind     = stbs_pkg::KIND_LOAD;
    elem_t                      s_value    = '0;
    logic                       s_last     = 1'b0;
    logic                       m_valid;
    logic                       m_ready    = 1'b0;
    logic                       m_found;
    logic [stbs_pkg::POS_W-1:0] m_position;
    logic                       m_overflow;

    sorted_set_tracker tracker = new();

    bit send_idle  = 1'b1;
    bit recv_idle  = 1'b1;
    int words_sent = 0;
    int quiet_cycles = 0;

    sort_then_binary_search i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_value    (s_value),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_position (m_position),
        .m_overflow (m_overflow)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: random stall before each word, none while recv_idle is off
    initial begin
        int stall;
        forever begin
            stall = recv_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) @(posedge aclk);
        end
    end

    // Check each accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_found, m_position, m_overflow);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Drive one input word, wait for its acceptance, then record it
    task automatic send_word(logic kind, elem_t value, logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        s_last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_word(kind, value, last);
        words_sent++;
    endtask

    // Hold off the sender until every pending search has answered
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    function automatic elem_t pick_value();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom_range(0, 8)) - 4;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
            default: return elem_t'($urandom);
        endcase
    endfunction

    initial begin
        elem_t falling[8];
        elem_t pool[$];
        elem_t key;
        int    n_loads;
        int    n_srch;
        int    r;

        falling = '{32'sh7FFFFFFF, 32'sh55555555, 32'sd7, 32'sd1, 32'sd0, -32'sd1,
                    32'shAAAAAAAA, 32'sh80000000};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // search before anything was loaded: empty set
        send_word(stbs_pkg::KIND_SRCH, 32'sd0, 1'b0);

        // full set in falling order, sorted by the closing load
        for (int i = 0; i < 8; i++) begin
            send_word(stbs_pkg::KIND_LOAD, falling[i], i == 7);
        end
        send_word(stbs_pkg::KIND_SRCH, 32'sh80000000, 1'b0);
        send_word(stbs_pkg::KIND_SRCH, 32'sh7FFFFFFF, 1'b0);
        send_word(stbs_pkg::KIND_SRCH, -32'sd1, 1'b0);
        // absent key, last flag on a search is ignored
        send_word(stbs_pkg::KIND_SRCH, 32'sd2, 1'b1);
        drain_results();

        // search while the set is still open
        send_word(stbs_pkg::KIND_LOAD, 32'sd5, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, -32'sd3, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, 32'sd9, 1'b0);
        send_word(stbs_pkg::KIND_SRCH, 32'sd9, 1'b0);

        // fill past the store; the dropped ninth load still closes the set
        send_word(stbs_pkg::KIND_LOAD, 32'sd4, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, 32'sd4, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, 32'sd8, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, -32'sd7, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, 32'sd100, 1'b0);
        send_word(stbs_pkg::KIND_LOAD, 32'sd2, 1'b1);
        send_word(stbs_pkg::KIND_SRCH, 32'sd4, 1'b0);

        // single-element set clears the overflow flag
        send_word(stbs_pkg::KIND_LOAD, 32'sd42, 1'b1);
        send_word(stbs_pkg::KIND_SRCH, 32'sd42, 1'b0);

        // random part: mostly whole sets followed by searches, some noise
        while (words_sent < WORD_TARGET) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            pool.delete();
            if ($urandom_range(0, 4) != 0) begin
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                                      : $urandom_range(1, 8);
                for (int i = 0; i < n_loads; i++) begin
                    key = pick_value();
                    pool.push_back(key);
                    send_word(stbs_pkg::KIND_LOAD, key, i == n_loads - 1);
                end
                n_srch = $urandom_range(1, 6);
                for (int i = 0; i < n_srch; i++) begin
                    r   = $urandom_range(0, 9);
                    key = pool[$urandom_range(0, pool.size() - 1)];
                    if (r == 6) key = key + 1;
                    else if (r == 7) key = key - 1;
                    else if (r == 8) key = pick_value();
                    else if (r == 9) key = elem_t'($urandom);
                    send_word(stbs_pkg::KIND_SRCH, key, 1'($urandom_range(0, 1)));
                end
            end else begin
                // loose mix of loads and searches, sets left open or cut short
                n_loads = $urandom_range(1, 10);
                for (int i = 0; i < n_loads; i++) begin
                    if (pool.size() != 0 && $urandom_range(0, 1)) begin
                        key = pool[$urandom_range(0, pool.size() - 1)];
                    end else begin
                        key = pick_value();
                    end
                    if ($urandom_range(0, 1)) begin
                        pool.push_back(key);
                        send_word(stbs_pkg::KIND_LOAD, key, $urandom_range(0, 5) == 0);
                    end else begin
                        send_word(stbs_pkg::KIND_SRCH, key, 1'($urandom_range(0, 1)));
                    end
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end
        end

        // wind down: let every answer arrive, then allow for a late sort
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
